// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== rtl/apc_pkg.sv =====
// ----------------------------------------------------------------------------
// apc_pkg
// Types, sizes and codes shared by the access permission cache.
// ----------------------------------------------------------------------------
`default_nettype none

package apc_pkg;

    localparam int SETS      = 256;
    localparam int WAYS      = 4;
    localparam int MASK_BITS = 8;

    localparam int SETS_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit SETS_POW2  = ((SETS & (SETS - 1)) == 0);
    localparam int SUM_W      = 36;
    localparam int SUM_DIGITS = SUM_W / 4;

    typedef logic [1:0] op_t;
    localparam op_t OP_CHECK  = 2'd0;
    localparam op_t OP_RECORD = 2'd1;
    localparam op_t OP_PURGE  = 2'd2;
    localparam op_t OP_UNUSED = 2'd3;

    localparam logic [1:0] VERD_UNKNOWN = 2'd0;
    localparam logic [1:0] VERD_ALLOWED = 2'd1;
    localparam logic [1:0] VERD_DENIED  = 2'd2;

    localparam logic [1:0] STAT_UPDATED  = 2'd0;
    localparam logic [1:0] STAT_INSERTED = 2'd1;
    localparam logic [1:0] STAT_DROPPED  = 2'd2;
    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_FOUND    = 2'd1;

    typedef logic [MASK_BITS-1:0] mask_t;
    typedef logic [SETS_W-1:0]    set_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] object_id;
        logic [31:0] cred_id;
        logic [7:0]  request_mask;
        logic [7:0]  result_mask;
        logic        attr_valid;
    } cmd_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [1:0] status;
    } rsp_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] obj;
        logic [31:0] cred;
        mask_t       req;
        mask_t       grant;
        logic        attr;
        set_idx_t    set_idx;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        mask_t       known;
        mask_t       allowed;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_sts_t;

    function automatic mask_t to_mask(input logic [7:0] v);
        logic [39:0] t;
        t = {32'd0, v};
        return t[MASK_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/apc_front.sv =====
// ----------------------------------------------------------------------------
// apc_front
// Accepts transactions, decodes fields and works out the set index.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  apc_pkg::cmd_t  cmd,
    input  apc_pkg::q_sts_t q_sts,
    output logic           push,
    output apc_pkg::item_t item
);
    import apc_pkg::*;

    logic             hv_reg, hv_next;
    logic             busy_reg, busy_next;
    logic [5:0]       step_reg, step_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SETS_W-1:0] rem_reg, rem_next;
    item_t            item_reg, item_next;
    logic             accept;
    logic [SUM_W-1:0] sum_in;
    logic [SETS_W+3:0] rem_t;
    logic [SETS_W+3:0] sub_t;
    logic [SETS_W+3:0] rem_d;

    assign push      = hv_reg && !busy_reg && !q_sts.full;
    assign cmd_stall = hv_reg && !push;
    assign accept    = cmd_valid && !cmd_stall;
    assign item      = item_reg;
    assign sum_in    = {{(SUM_W-32){1'b0}}, cmd.object_id} + {{(SUM_W-32){1'b0}}, cmd.cred_id};

    always_comb
    begin
        hv_next   = hv_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        sum_next  = sum_reg;
        rem_next  = rem_reg;
        item_next = item_reg;
        rem_t     = {rem_reg, sum_reg[SUM_W-1 -: 4]};
        sub_t     = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (rem_t >= (SETS_W+4)'(k * SETS))
            begin
                sub_t = (SETS_W+4)'(k * SETS);
            end
        end
        rem_d = rem_t - sub_t;
        if (push)
        begin
            hv_next = 1'b0;
        end
        if (busy_reg)
        begin
            rem_next  = rem_d[SETS_W-1:0];
            sum_next  = {sum_reg[SUM_W-5:0], 4'b0000};
            step_next = step_reg + 6'd1;
            if (step_reg == 6'(SUM_DIGITS - 1))
            begin
                busy_next         = 1'b0;
                item_next.set_idx = rem_d[SETS_W-1:0];
            end
        end
        if (accept)
        begin
            hv_next         = 1'b1;
            item_next.op    = cmd.operation;
            item_next.obj   = cmd.object_id;
            item_next.cred  = cmd.cred_id;
            item_next.req   = to_mask(cmd.request_mask);
            item_next.grant = to_mask(cmd.result_mask);
            item_next.attr  = cmd.attr_valid;
            sum_next        = sum_in;
            step_next       = 6'd0;
            rem_next        = '0;
            if (SETS_POW2)
            begin
                item_next.set_idx = sum_in[SETS_W-1:0] & SETS_W'(SETS - 1);
                busy_next         = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg   <= 1'b0;
            busy_reg <= 1'b0;
            step_reg <= 6'd0;
        end
        else
        begin
            hv_reg   <= hv_next;
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

// ===== rtl/apc_queue.sv =====
// ----------------------------------------------------------------------------
// apc_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  apc_pkg::q_ctl_t ctl,
    input  apc_pkg::item_t  wr_item,
    output apc_pkg::q_sts_t sts,
    output apc_pkg::item_t  rd_item
);
    import apc_pkg::*;

    item_t      slot_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign sts.full  = (cnt_reg == 2'd2);
    assign sts.empty = (cnt_reg == 2'd0);
    assign do_push   = ctl.push && !sts.full;
    assign do_pop    = ctl.pop && !sts.empty;
    assign rd_item   = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/apc_back.sv =====
// ----------------------------------------------------------------------------
// apc_back
// Set memory, reset clear, lookup, update and purge scan; drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  apc_pkg::q_sts_t q_sts,
    input  apc_pkg::item_t  q_item,
    output logic            pop,
    output logic            res_valid,
    input  logic            res_stall,
    output apc_pkg::rsp_t   res
);
    import apc_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    row_t        mem [SETS];
    row_t        rd_data_reg;
    logic        rd_en, wr_en;
    set_idx_t    rd_addr, wr_addr;
    row_t        wr_data;

    state_t      state_reg, state_next;
    logic [SETS_W:0] cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    logic        found_reg, found_next;
    logic        out_valid_reg, out_valid_next;
    set_idx_t    paddr_reg, paddr_next;
    item_t       cur_reg, cur_next;
    rsp_t        out_reg, out_next;

    logic        out_free;
    logic        hit_f, free_f, any_obj;
    logic [WAY_W-1:0] hit_w, free_w;
    logic [63:0] key;
    row_t        row_mod;

    assign out_free  = !out_valid_reg || !res_stall;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign key       = {cur_reg.obj, cur_reg.cred};

    always_comb
    begin
        hit_f   = 1'b0;
        free_f  = 1'b0;
        hit_w   = '0;
        free_w  = '0;
        any_obj = 1'b0;
        row_mod = rd_data_reg;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rd_data_reg[w].valid && rd_data_reg[w].key == key)
            begin
                hit_f = 1'b1;
                hit_w = WAY_W'(w);
            end
            if (!rd_data_reg[w].valid)
            begin
                free_f = 1'b1;
                free_w = WAY_W'(w);
            end
            if (rd_data_reg[w].valid && rd_data_reg[w].key[63:32] == cur_reg.obj)
            begin
                any_obj            = 1'b1;
                row_mod[w].valid   = 1'b0;
                row_mod[w].known   = '0;
                row_mod[w].allowed = '0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        paddr_next     = paddr_reg;
        cur_next       = cur_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = q_item.set_idx;
        wr_en          = 1'b0;
        wr_addr        = cur_reg.set_idx;
        wr_data        = rd_data_reg;
        pop            = 1'b0;
        if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[SETS_W-1:0];
                wr_data  = '0;
                cnt_next = cnt_reg + (SETS_W+1)'(1);
                if (cnt_reg == (SETS_W+1)'(SETS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_sts.empty)
                begin
                    pop      = 1'b1;
                    cur_next = q_item;
                    if (q_item.op == OP_PURGE)
                    begin
                        cnt_next   = '0;
                        pend_next  = 1'b0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    state_next     = S_IDLE;
                    case (cur_reg.op)
                        OP_CHECK:
                        begin
                            if (cur_reg.attr && hit_f &&
                                (rd_data_reg[hit_w].known & cur_reg.req) == cur_reg.req)
                            begin
                                out_next.verdict =
                                    ((rd_data_reg[hit_w].allowed & cur_reg.req) == cur_reg.req)
                                    ? VERD_ALLOWED : VERD_DENIED;
                            end
                        end
                        OP_RECORD:
                        begin
                            if (hit_f)
                            begin
                                wr_en                  = 1'b1;
                                wr_data[hit_w].known   = rd_data_reg[hit_w].known | cur_reg.req;
                                wr_data[hit_w].allowed =
                                    (rd_data_reg[hit_w].allowed & ~cur_reg.req) | cur_reg.grant;
                                out_next.status        = STAT_UPDATED;
                            end
                            else if (free_f)
                            begin
                                wr_en                   = 1'b1;
                                wr_data[free_w].valid   = 1'b1;
                                wr_data[free_w].key     = key;
                                wr_data[free_w].known   = cur_reg.req;
                                wr_data[free_w].allowed = cur_reg.grant;
                                out_next.status         = STAT_INSERTED;
                            end
                            else
                            begin
                                out_next.status = STAT_DROPPED;
                            end
                        end
                        default:
                        begin
                            out_next = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                pend_next = (cnt_reg < (SETS_W+1)'(SETS));
                if (cnt_reg < (SETS_W+1)'(SETS))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cnt_reg[SETS_W-1:0];
                    paddr_next = cnt_reg[SETS_W-1:0];
                    cnt_next   = cnt_reg + (SETS_W+1)'(1);
                end
                if (pend_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = paddr_reg;
                    wr_data    = row_mod;
                    found_next = found_reg | any_obj;
                end
                else if (cnt_reg == (SETS_W+1)'(SETS))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = '0;
                    out_next.status = found_reg ? STAT_FOUND : STAT_NONE;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        paddr_reg <= paddr_next;
        cur_reg   <= cur_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/access_permission_cache.sv =====
// ----------------------------------------------------------------------------
// access_permission_cache
// Hashed set-associative cache of access permissions per object/credential.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel carries one operation per transaction (check, record, purge);
//   res channel returns exactly one verdict/status transaction per command.
//   A transaction moves on a rising edge with valid high and stall low.
//   A check or record passes the front register and the queue; the back end
//   takes it only when idle and does one set read, then compare and write
//   back, before it takes the next command.
//   Purge walks every set, one row read and one row write per cycle on
//   separate read and write ports.
//   For a set count that is not a power of two the front works out the set
//   index one hex digit of the sum per cycle.
//   After reset the back end clears all SETS rows, one per cycle, before
//   taking work; commands queue meanwhile (two in the queue, one in front).
//   A stalled result holds in the output register; the back end waits and
//   the queue and front fill, then cmd_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module access_permission_cache (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  apc_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output apc_pkg::rsp_t res
);
    import apc_pkg::*;

    q_ctl_t q_ctl;
    q_sts_t q_sts;
    item_t  f_item;
    item_t  q_item;
    logic   push;
    logic   pop;

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    apc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_sts     (q_sts),
        .push      (push),
        .item      (f_item)
    );

    apc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (q_ctl),
        .wr_item (f_item),
        .sts     (q_sts),
        .rd_item (q_item)
    );

    apc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_sts     (q_sts),
        .q_item    (q_item),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

`default_nettype wire

// ===== rtl/apc_checker.sv =====
// ----------------------------------------------------------------------------
// apc_checker
// Port-level checks on the channels of the permission cache.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module apc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input apc_pkg::cmd_t cmd,
    input logic          res_valid,
    input logic          res_stall,
    input apc_pkg::rsp_t res
);
    import apc_pkg::*;

    `AST_NEXT(a_cmd_hold, clk, rst_n, cmd_valid && cmd_stall, cmd_valid && $stable(cmd))
    `AST_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res))
    `AST_IMPLY(a_verdict_code, clk, rst_n, res_valid, res.verdict <= VERD_DENIED)
    `AST_IMPLY(a_status_code, clk, rst_n, res_valid, res.status <= STAT_DROPPED)
    `AST_IMPLY(a_verdict_only, clk, rst_n, res_valid && res.verdict != VERD_UNKNOWN,
               res.status == STAT_NONE)

endmodule

bind access_permission_cache apc_checker u_apc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

// ===== tb/sv/apc_checker.sv =====
// ----------------------------------------------------------------------------
// apc_scoreboard
// Watches the command and result channels of the permission cache, keeps a
// model of its sets and compares each result with the predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apc_scoreboard
    import apc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    input  logic  cmd_stall,
    input  cmd_t  cmd,
    input  logic  res_valid,
    input  logic  res_stall,
    input  rsp_t  res,
    output int    fail_count,
    output int    pending_count
);

    logic [63:0] way_key [SETS*WAYS];
    logic        way_valid [SETS*WAYS];
    mask_t       way_known [SETS*WAYS];
    mask_t       way_allowed [SETS*WAYS];
    rsp_t        expected_rsp [$];

    function automatic int set_base(input logic [31:0] obj, input logic [31:0] cred);
        logic [32:0] total;
        total = {1'b0, obj} + {1'b0, cred};
        return int'(total % SETS) * WAYS;
    endfunction

    function automatic rsp_t predict_cache(input cmd_t c);
        rsp_t        r;
        int          base;
        int          hit;
        logic [63:0] key;
        mask_t       req;
        mask_t       grant;
        r     = '0;
        base  = set_base(c.object_id, c.cred_id);
        key   = {c.object_id, c.cred_id};
        req   = c.request_mask[MASK_BITS-1:0];
        grant = c.result_mask[MASK_BITS-1:0];
        hit   = -1;
        for (int w = 0; w < WAYS; w++)
            if (hit < 0 && way_valid[base+w] && way_key[base+w] == key)
                hit = base + w;
        case (c.operation)
            OP_CHECK:
            begin
                if (c.attr_valid && hit >= 0 && (way_known[hit] & req) == req)
                    r.verdict = ((way_allowed[hit] & req) == req) ? VERD_ALLOWED
                                                                   : VERD_DENIED;
            end
            OP_RECORD:
            begin
                if (hit >= 0)
                begin
                    way_known[hit]   = way_known[hit] | req;
                    way_allowed[hit] = (way_allowed[hit] & ~req) | grant;
                    r.status = STAT_UPDATED;
                end
                else
                begin
                    r.status = STAT_DROPPED;
                    for (int w = 0; w < WAYS; w++)
                        if (r.status == STAT_DROPPED && !way_valid[base+w])
                        begin
                            way_valid[base+w]   = 1'b1;
                            way_key[base+w]     = key;
                            way_known[base+w]   = req;
                            way_allowed[base+w] = grant;
                            r.status = STAT_INSERTED;
                        end
                end
            end
            OP_PURGE:
            begin
                r.status = STAT_NONE;
                for (int i = 0; i < SETS*WAYS; i++)
                    if (way_valid[i] && way_key[i][63:32] == c.object_id)
                    begin
                        way_valid[i]   = 1'b0;
                        way_known[i]   = '0;
                        way_allowed[i] = '0;
                        r.status = STAT_FOUND;
                    end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SETS*WAYS; i++)
            begin
                way_valid[i]   = 1'b0;
                way_key[i]     = '0;
                way_known[i]   = '0;
                way_allowed[i] = '0;
            end
            expected_rsp.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transaction %h", res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (want.verdict !== res.verdict || want.status !== res.status)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: verdict exp %0d got %0d, status exp %0d got %0d",
                                     want.verdict, res.verdict, want.status, res.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                expected_rsp.push_back(predict_cache(cmd));
            pending_count <= expected_rsp.size();
        end
    end

endmodule

// ===== tb/sv/access_permission_cache_tb.sv =====
// ----------------------------------------------------------------------------
// access_permission_cache_tb
// Drives checks, records, purges and unused op codes into the permission cache
// with random gaps and result stalls, one long hold-off; the scoreboard scores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module access_permission_cache_tb;
    import apc_pkg::*;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    rsp_t res;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    bit   feed_done;
    bit   hold_off;

    logic [31:0] obj_pool [8];
    logic [31:0] cred_pool [8];

    access_permission_cache uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    apc_scoreboard u_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res           (res),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic send_cmd(input cmd_t c);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic cmd_t make_cmd(input op_t op, input logic [31:0] obj,
                                      input logic [31:0] cred, input logic [7:0] req,
                                      input logic [7:0] grant, input logic attr);
        cmd_t c;
        c.operation    = op;
        c.object_id    = obj;
        c.cred_id      = cred;
        c.request_mask = req;
        c.result_mask  = grant;
        c.attr_valid   = attr;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        c    = cmd_t'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c.operation = OP_CHECK;
        else if (pick < 88)
            c.operation = OP_RECORD;
        else if (pick < 96)
            c.operation = OP_PURGE;
        else
            c.operation = OP_UNUSED;
        if ($urandom_range(0, 9) != 0)
        begin
            c.object_id = obj_pool[$urandom_range(0, 7)];
            c.cred_id   = cred_pool[$urandom_range(0, 7)];
        end
        if ($urandom_range(0, 9) != 0)
            c.attr_valid = 1'b1;
        return c;
    endfunction

    initial
    begin
        cmd_valid = 1'b0;
        cmd       = '0;
        rst_n     = 1'b0;
        feed_done = 1'b0;
        hold_off  = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            obj_pool[i]  = (i < 4) ? 32'h100 * i : $urandom;
            cred_pool[i] = (i < 4) ? SETS * i : $urandom;
        end
        obj_pool[7]  = 32'hFFFF_FFFF;
        cred_pool[7] = 32'hFFFF_FFFF;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_cmd(make_cmd(OP_CHECK, 32'h0, 32'h0, 8'h01, 8'h00, 1'b1));
        send_cmd(make_cmd(OP_RECORD, 32'h0, 32'h0, 8'hFF, 8'hA5, 1'b0));
        send_cmd(make_cmd(OP_CHECK, 32'h0, 32'h0, 8'h05, 8'h00, 1'b1));
        send_cmd(make_cmd(OP_CHECK, 32'h0, 32'h0, 8'h03, 8'h00, 1'b1));
        send_cmd(make_cmd(OP_CHECK, 32'h0, 32'h0, 8'h00, 8'h00, 1'b1));
        send_cmd(make_cmd(OP_CHECK, 32'h0, 32'h0, 8'h01, 8'h00, 1'b0));
        send_cmd(make_cmd(OP_RECORD, 32'h0, 32'h0, 8'h0F, 8'h5A, 1'b1));
        send_cmd(make_cmd(OP_CHECK, 32'h0, 32'h0, 8'hFF, 8'h00, 1'b1));
        send_cmd(make_cmd(OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'hFF, 1'b1));
        send_cmd(make_cmd(OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h01, 8'h00, 1'b1));
        for (int i = 1; i <= 5; i++)
            send_cmd(make_cmd(OP_RECORD, 32'h7 * i, SETS * i - 32'h7 * i + 32'h7,
                              8'h11, 8'h01, 1'b1));
        send_cmd(make_cmd(OP_UNUSED, 32'h7, 32'h7, 8'hFF, 8'hFF, 1'b1));
        send_cmd(make_cmd(OP_PURGE, 32'h7, 32'h0, 8'h00, 8'h00, 1'b0));
        send_cmd(make_cmd(OP_PURGE, 32'h7, 32'h0, 8'h00, 8'h00, 1'b0));
        send_cmd(make_cmd(OP_RECORD, 32'h7, SETS, 8'h11, 8'h01, 1'b1));
        send_cmd(make_cmd(OP_PURGE, 32'hFFFF_FFFF, 32'h0, 8'h00, 8'h00, 1'b1));

        hold_off = 1'b1;
        for (int n = 0; n < 450; n++)
            send_cmd(random_cmd());
        cmd_valid <= 1'b0;
        feed_done = 1'b1;
    end

    initial
    begin
        res_stall = 1'b0;
        @(posedge hold_off);
        @(negedge clk);
        res_stall <= 1'b1;
        repeat (200) @(negedge clk);
        res_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                repeat (gap_len() + 1) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (!(feed_done && pending_count == 0) && cycle_count < 1000000)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= 1000000)
            $display("CHECKS FAILED");
        else
        begin
            repeat (SETS + 50) @(posedge clk);
            if (fail_count == 0 && pending_count == 0)
                $display("ALL CHECKS PASSED");
            else
                $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
